// ----- hdl/msra_pkg.sv -----
// ----------------------------------------------------------------------------
// msra_pkg
// Shared widths, command codes and queue item type for the set/reset
// offset-cancelling magnetometer averager.
// ----------------------------------------------------------------------------
package msra_pkg;

  localparam int AXIS_BITS       = 20;
  localparam int FIELD_BITS      = 16;
  localparam int BYTE_BITS       = 8;
  localparam int NUM_AXES        = 3;
  localparam int CMD_BITS        = 2;
  localparam int COUNT_BITS_DEF  = 8;
  localparam int SAMPLE_CNT_BITS = 8;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_BITS       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  // input tdata layout, lowest byte first
  localparam int IN_DATA_BITS  = 9 * BYTE_BITS;
  localparam int OUT_DATA_BITS = NUM_AXES * FIELD_BITS;

  // phase commands on the input channel
  localparam logic [CMD_BITS-1:0] CMD_RESET_READ = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_FIRST_SET  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_MORE_SET   = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED     = 2'd3;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_OFFSET = 2'd0,
    OP_FIRST  = 2'd1,
    OP_ACCUM  = 2'd2
  } msra_op_t;

  typedef struct packed {
    msra_op_t                               op;
    logic [NUM_AXES-1:0][AXIS_BITS-1:0]     axis;
  } msra_item_t;

  // queue status seen by the producer and the consumer
  typedef struct packed {
    logic full;
    logic empty;
  } msra_qstat_t;

endpackage

// ----- hdl/msra_front.sv -----
// ----------------------------------------------------------------------------
// msra_front
// Accepts raw measurement transfers, unpacks the three 20-bit axes and
// classifies the phase command into a queue operation.
// ----------------------------------------------------------------------------
module msra_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [msra_pkg::IN_DATA_BITS-1:0]  in_tdata,
  input  logic [msra_pkg::CMD_BITS-1:0]      in_tuser,
  input  msra_pkg::msra_qstat_t              q_stat,
  output logic                               push_valid,
  output msra_pkg::msra_item_t               push_item
);
  import msra_pkg::*;

  logic [NUM_AXES-1:0][BYTE_BITS-1:0] byte_hi;
  logic [NUM_AXES-1:0][BYTE_BITS-1:0] byte_mid;
  logic [NUM_AXES-1:0][BYTE_BITS-1:0] byte_lo;
  logic                               keep;

  // byte positions: x hi, x mid, y hi, y mid, z hi, z mid, x lo, y lo, z lo
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      byte_hi[k]  = in_tdata[(2*k)*BYTE_BITS +: BYTE_BITS];
      byte_mid[k] = in_tdata[(2*k+1)*BYTE_BITS +: BYTE_BITS];
      byte_lo[k]  = in_tdata[(6+k)*BYTE_BITS +: BYTE_BITS];
    end
  end

  // unpack each axis: hi << 12 | mid << 4 | lo >> 4
  // classify the command; the unused code is dropped here
  always_comb begin
    keep         = 1'b1;
    push_item.op = OP_OFFSET;
    for (int k = 0; k < NUM_AXES; k++) begin
      push_item.axis[k] = {byte_hi[k], byte_mid[k], byte_lo[k][BYTE_BITS-1:4]};
    end
    unique case (in_tuser)
      CMD_RESET_READ: push_item.op = OP_OFFSET;
      CMD_FIRST_SET:  push_item.op = OP_FIRST;
      CMD_MORE_SET:   push_item.op = OP_ACCUM;
      CMD_UNUSED:     keep = 1'b0;
      default:        keep = 1'b0;
    endcase
  end

  assign in_tready  = !q_stat.full;
  assign push_valid = in_tvalid && in_tready && keep;

endmodule

// ----- hdl/msra_queue.sv -----
// ----------------------------------------------------------------------------
// msra_queue
// Short first-in first-out queue of classified operations between the
// front and the back.
// ----------------------------------------------------------------------------
module msra_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  msra_pkg::msra_item_t  wr_item,
  input  logic                  rd_en,
  output msra_pkg::msra_item_t  rd_item,
  output msra_pkg::msra_qstat_t stat
);
  import msra_pkg::*;

  msra_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    ptr_inc = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_en ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (!stat.full || rd_en))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !stat.empty)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

// ----- hdl/msra_back.sv -----
// ----------------------------------------------------------------------------
// msra_back
// Holds offsets, sums and run state, applies queued operations and, when a
// run completes, divides the three sums by the count with three bit-serial
// restoring dividers before loading the output register.
// ----------------------------------------------------------------------------
module msra_back #(
  parameter int COUNT_BITS = msra_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [msra_pkg::SAMPLE_CNT_BITS-1:0] cfg_wr_data,
  input  msra_pkg::msra_qstat_t                q_stat,
  input  msra_pkg::msra_item_t                 q_item,
  output logic                                 q_rd_en,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [msra_pkg::OUT_DATA_BITS-1:0]   out_tdata
);
  import msra_pkg::*;

  localparam int SUM_BITS  = AXIS_BITS + COUNT_BITS;
  localparam int BCNT_BITS = $clog2(SUM_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } back_state_t;

  back_state_t                             state_r, state_nxt;
  logic [SAMPLE_CNT_BITS-1:0]              samp_cnt_r, samp_cnt_nxt;
  logic [NUM_AXES-1:0][AXIS_BITS-1:0]      offset_r, offset_nxt;
  logic [NUM_AXES-1:0][SUM_BITS-1:0]       sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]                   done_r, done_nxt;
  logic                                    run_r, run_nxt;
  logic [NUM_AXES-1:0][SUM_BITS-1:0]       quo_r, quo_nxt;
  logic [NUM_AXES-1:0][COUNT_BITS-1:0]     rem_r, rem_nxt;
  logic [BCNT_BITS-1:0]                    bit_cnt_r, bit_cnt_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  logic [NUM_AXES-1:0][FIELD_BITS-1:0]     out_data_r, out_data_nxt;

  logic [COUNT_BITS-1:0]                   cnt_masked;
  logic [COUNT_BITS-1:0]                   cnt_use;
  logic [COUNT_BITS:0]                     trial [NUM_AXES];
  logic                                    out_load;
  logic [AXIS_BITS:0]                      avg_sum;

  // count in use: masked to the counter width, zero taken as one
  assign cnt_masked = COUNT_BITS'(samp_cnt_r);
  assign cnt_use    = (cnt_masked == '0) ? COUNT_BITS'(1) : cnt_masked;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign q_rd_en  = (state_r == ST_IDLE) && !q_stat.empty;

  // divider trial subtraction, one quotient bit per axis per cycle
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      trial[k] = {rem_r[k], quo_r[k][SUM_BITS-1]};
    end
  end

  // next state of the back end
  always_comb begin
    state_nxt     = state_r;
    samp_cnt_nxt  = cfg_wr_en ? cfg_wr_data : samp_cnt_r;
    offset_nxt    = offset_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    run_nxt       = run_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    avg_sum       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_rd_en) begin
          unique case (q_item.op)
            OP_OFFSET: begin
              offset_nxt = q_item.axis;
              run_nxt    = 1'b0;
            end
            OP_FIRST: begin
              for (int k = 0; k < NUM_AXES; k++) begin
                avg_sum       = {1'b0, offset_r[k]} + {1'b0, q_item.axis[k]};
                offset_nxt[k] = avg_sum[AXIS_BITS:1];
                sum_nxt[k]    = SUM_BITS'(q_item.axis[k]);
              end
              done_nxt = COUNT_BITS'(1);
              run_nxt  = 1'b1;
            end
            OP_ACCUM: begin
              if (run_r) begin
                for (int k = 0; k < NUM_AXES; k++) begin
                  sum_nxt[k] = sum_r[k] + SUM_BITS'(q_item.axis[k]);
                end
                done_nxt = done_r + COUNT_BITS'(1);
              end
            end
            default: ;
          endcase
          // run complete: start the dividers on the updated sums
          if (run_nxt && (done_nxt >= cnt_use)) begin
            run_nxt     = 1'b0;
            quo_nxt     = sum_nxt;
            rem_nxt     = '0;
            bit_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        for (int k = 0; k < NUM_AXES; k++) begin
          if (trial[k] >= {1'b0, cnt_use}) begin
            rem_nxt[k] = COUNT_BITS'(trial[k] - {1'b0, cnt_use});
            quo_nxt[k] = {quo_r[k][SUM_BITS-2:0], 1'b1};
          end else begin
            rem_nxt[k] = trial[k][COUNT_BITS-1:0];
            quo_nxt[k] = {quo_r[k][SUM_BITS-2:0], 1'b0};
          end
        end
        bit_cnt_nxt = bit_cnt_r + BCNT_BITS'(1);
        if (bit_cnt_r == BCNT_BITS'(SUM_BITS - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // quotient minus offset, wrapped to 16 bits
        if (out_load) begin
          for (int k = 0; k < NUM_AXES; k++) begin
            out_data_nxt[k] = quo_r[k][FIELD_BITS-1:0] - offset_r[k][FIELD_BITS-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      samp_cnt_r  <= SAMPLE_CNT_BITS'(1);
      offset_r    <= '0;
      sum_r       <= '0;
      done_r      <= '0;
      run_r       <= 1'b0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      samp_cnt_r  <= samp_cnt_nxt;
      offset_r    <= offset_nxt;
      sum_r       <= sum_nxt;
      done_r      <= done_nxt;
      run_r       <= run_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_result_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result appeared without a finished division");
  a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (bit_cnt_r < BCNT_BITS'(SUM_BITS)))
    else $error("divider ran past the sum width");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !q_rd_en)
    else $error("queue popped while back end busy");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !run_r)
    else $error("run still active during final division");
`endif

endmodule

// ----- hdl/magnetometer_set_reset_averager_core.sv -----
// Item flow: an item that gives no result is queued, then popped and applied
// by the back end when idle. An item that completes a run is then divided by
// the bit-serial dividers, one per axis running side by side, one quotient
// bit per cycle, before its result is loaded into the output register.
// Throughput: one item a cycle, but only while the back end is in ST_IDLE.
// Reset: synchronous active-low; clears queue, offsets, sums, run, count to 1.
// ----------------------------------------------------------------------------
// magnetometer_set_reset_averager_core
// Set/reset offset-cancelling averager for a three-axis magnetometer: front
// unpacks and classifies reads, a short queue decouples it from the back end.
// ----------------------------------------------------------------------------
module magnetometer_set_reset_averager_core #(
  parameter int COUNT_BITS = msra_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample count register
  input  logic                                 cfg_wr_en,
  input  logic [msra_pkg::SAMPLE_CNT_BITS-1:0] cfg_wr_data,
  // measurement input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_byte_high, x_byte_mid, y_byte_high, y_byte_mid, z_byte_high,
  // z_byte_mid, x_byte_low, y_byte_low, z_byte_low (8 bits each)
  input  logic [msra_pkg::IN_DATA_BITS-1:0]    in_tdata,
  // cmd
  input  logic [msra_pkg::CMD_BITS-1:0]        in_tuser,
  // result output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // field_x, field_y, field_z (16 bits each, signed)
  output logic [msra_pkg::OUT_DATA_BITS-1:0]   out_tdata
);
  import msra_pkg::*;

  logic        push_valid;
  msra_item_t  push_item;
  logic        pop;
  msra_item_t  pop_item;
  msra_qstat_t q_stat;

  msra_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  msra_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push_valid),
    .wr_item (push_item),
    .rd_en   (pop),
    .rd_item (pop_item),
    .stat    (q_stat)
  );

  msra_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_item      (pop_item),
    .q_rd_en     (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule
